FILE: src/lsss_pkg.sv
package lsss_pkg;

  localparam int COORD_BITS_DEF    = 24;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int TOL_BITS          = 24;
  localparam int CFG_IDX_BITS      = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_ZERO_TOL = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_WHOLE_FRONT = 2'd0,
    CLS_WHOLE_BACK  = 2'd1,
    CLS_SPLIT_POS   = 2'd2,
    CLS_SPLIT_NEG   = 2'd3
  } cls_t;

endpackage

FILE: src/lsss_cross.sv
module lsss_cross #(
  parameter int COORD_BITS = lsss_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_v,
  input  logic signed [COORD_BITS-1:0] sx,
  input  logic signed [COORD_BITS-1:0] sy,
  input  logic signed [COORD_BITS-1:0] ex,
  input  logic signed [COORD_BITS-1:0] ey,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] dx,
  input  logic signed [COORD_BITS-1:0] dy,
  output logic                         v_o,
  output logic signed [2*COORD_BITS+2:0] num_o,
  output logic signed [2*COORD_BITS+2:0] den_o,
  output logic signed [COORD_BITS-1:0] sx_o,
  output logic signed [COORD_BITS-1:0] sy_o,
  output logic signed [COORD_BITS-1:0] ex_o,
  output logic signed [COORD_BITS-1:0] ey_o
);
  localparam int CW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 1;
  localparam int XW = 2 * COORD_BITS + 3;

  logic signed [CW-1:0] ax_r, ay_r, vx_r, vy_r;
  logic signed [COORD_BITS-1:0] dx_r, dy_r;
  logic signed [COORD_BITS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic v1_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [COORD_BITS-1:0] sx2_r, sy2_r, ex2_r, ey2_r;
  logic v2_r;
  logic signed [XW-1:0] num_r, den_r;
  logic signed [COORD_BITS-1:0] sx3_r, sy3_r, ex3_r, ey3_r;
  logic v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r  <= CW'(sx) - CW'(px);
      ay_r  <= CW'(sy) - CW'(py);
      vx_r  <= CW'(ex) - CW'(sx);
      vy_r  <= CW'(ey) - CW'(sy);
      dx_r  <= dx;
      dy_r  <= dy;
      sx_r  <= sx;
      sy_r  <= sy;
      ex_r  <= ex;
      ey_r  <= ey;
      p0_r  <= PW'(ax_r * dy_r);
      p1_r  <= PW'(ay_r * dx_r);
      p2_r  <= PW'(dx_r * vy_r);
      p3_r  <= PW'(dy_r * vx_r);
      sx2_r <= sx_r;
      sy2_r <= sy_r;
      ex2_r <= ex_r;
      ey2_r <= ey_r;
      num_r <= XW'(p0_r) - XW'(p1_r);
      den_r <= XW'(p2_r) - XW'(p3_r);
      sx3_r <= sx2_r;
      sy3_r <= sy2_r;
      ex3_r <= ex2_r;
      ey3_r <= ey2_r;
    end
  end

  assign v_o   = v3_r;
  assign num_o = num_r;
  assign den_o = den_r;
  assign sx_o  = sx3_r;
  assign sy_o  = sy3_r;
  assign ex_o  = ex3_r;
  assign ey_o  = ey3_r;
endmodule

FILE: src/lsss_divide.sv
module lsss_divide #(
  parameter int COORD_BITS    = lsss_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = lsss_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_v,
  input  logic signed [2*COORD_BITS+2:0] num,
  input  logic signed [2*COORD_BITS+2:0] den,
  input  logic [lsss_pkg::TOL_BITS-1:0] tol,
  input  logic signed [COORD_BITS-1:0]  sx,
  input  logic signed [COORD_BITS-1:0]  sy,
  input  logic signed [COORD_BITS-1:0]  ex,
  input  logic signed [COORD_BITS-1:0]  ey,
  output logic                          v_o,
  output lsss_pkg::cls_t                cls_o,
  output logic [FRACTION_BITS-1:0]      q_o,
  output logic signed [COORD_BITS-1:0]  sx_o,
  output logic signed [COORD_BITS-1:0]  sy_o,
  output logic signed [COORD_BITS-1:0]  ex_o,
  output logic signed [COORD_BITS-1:0]  ey_o
);
  localparam int XW = 2 * COORD_BITS + 3;
  localparam int RW = XW + 1;
  localparam int NS = FRACTION_BITS + 1;

  logic                 v_r   [NS];
  lsss_pkg::cls_t       cls_r [NS];
  logic [RW-1:0]        rem_r [NS];
  logic [RW-1:0]        dv_r  [NS];
  logic [FRACTION_BITS-1:0] q_r [NS];
  logic signed [COORD_BITS-1:0] sx_r [NS];
  logic signed [COORD_BITS-1:0] sy_r [NS];
  logic signed [COORD_BITS-1:0] ex_r [NS];
  logic signed [COORD_BITS-1:0] ey_r [NS];

  logic [XW-1:0] an, ad;
  logic nz, dz, nneg, dneg, nzero;
  lsss_pkg::cls_t cls_c;

  always_comb begin
    nneg  = num[XW-1];
    dneg  = den[XW-1];
    an    = nneg ? XW'(-num) : XW'(num);
    ad    = dneg ? XW'(-den) : XW'(den);
    nzero = (num == '0);
    nz    = nzero || (an < XW'(tol));
    dz    = (den == '0) || (ad < XW'(tol));
    if (dz && nz) begin
      cls_c = lsss_pkg::CLS_WHOLE_FRONT;
    end else if (dz) begin
      cls_c = nneg ? lsss_pkg::CLS_WHOLE_FRONT : lsss_pkg::CLS_WHOLE_BACK;
    end else if (!nzero && (nneg == dneg) && (an < ad)) begin
      cls_c = nneg ? lsss_pkg::CLS_SPLIT_NEG : lsss_pkg::CLS_SPLIT_POS;
    end else if (nneg || (nz && !dneg)) begin
      cls_c = lsss_pkg::CLS_WHOLE_FRONT;
    end else begin
      cls_c = lsss_pkg::CLS_WHOLE_BACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_v;
      for (int i = 1; i < NS; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_r[0] <= cls_c;
      rem_r[0] <= RW'(an);
      dv_r[0]  <= RW'(ad);
      q_r[0]   <= '0;
      sx_r[0]  <= sx;
      sy_r[0]  <= sy;
      ex_r[0]  <= ex;
      ey_r[0]  <= ey;
      for (int i = 1; i < NS; i++) begin
        cls_r[i] <= cls_r[i-1];
        dv_r[i]  <= dv_r[i-1];
        sx_r[i]  <= sx_r[i-1];
        sy_r[i]  <= sy_r[i-1];
        ex_r[i]  <= ex_r[i-1];
        ey_r[i]  <= ey_r[i-1];
        if ({rem_r[i-1][RW-2:0], 1'b0} >= dv_r[i-1]) begin
          rem_r[i] <= {rem_r[i-1][RW-2:0], 1'b0} - dv_r[i-1];
          q_r[i]   <= {q_r[i-1][FRACTION_BITS-2:0], 1'b1};
        end else begin
          rem_r[i] <= {rem_r[i-1][RW-2:0], 1'b0};
          q_r[i]   <= {q_r[i-1][FRACTION_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign v_o   = v_r[NS-1];
  assign cls_o = cls_r[NS-1];
  assign q_o   = q_r[NS-1];
  assign sx_o  = sx_r[NS-1];
  assign sy_o  = sy_r[NS-1];
  assign ex_o  = ex_r[NS-1];
  assign ey_o  = ey_r[NS-1];
endmodule

FILE: src/lsss_cut.sv
module lsss_cut #(
  parameter int COORD_BITS    = lsss_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = lsss_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_v,
  input  lsss_pkg::cls_t               cls,
  input  logic [FRACTION_BITS-1:0]     q,
  input  logic signed [COORD_BITS-1:0] sx,
  input  logic signed [COORD_BITS-1:0] sy,
  input  logic signed [COORD_BITS-1:0] ex,
  input  logic signed [COORD_BITS-1:0] ey,
  output logic                         v_o,
  output lsss_pkg::cls_t               cls_o,
  output logic signed [COORD_BITS-1:0] ix_o,
  output logic signed [COORD_BITS-1:0] iy_o,
  output logic signed [COORD_BITS-1:0] sx_o,
  output logic signed [COORD_BITS-1:0] sy_o,
  output logic signed [COORD_BITS-1:0] ex_o,
  output logic signed [COORD_BITS-1:0] ey_o
);
  localparam int CW = COORD_BITS + 1;
  localparam int MW = CW + FRACTION_BITS + 1;

  logic v1_r, v2_r;
  lsss_pkg::cls_t cls1_r, cls2_r;
  logic signed [MW-1:0] mx_r, my_r;
  logic signed [COORD_BITS-1:0] sx1_r, sy1_r, ex1_r, ey1_r;
  logic signed [COORD_BITS-1:0] ix_r, iy_r, sx2_r, sy2_r, ex2_r, ey2_r;
  logic signed [CW-1:0] vx, vy;
  logic signed [MW-1:0] rx, ry;

  assign vx = CW'(ex) - CW'(sx);
  assign vy = CW'(ey) - CW'(sy);
  assign rx = mx_r + (MW'(1) <<< (FRACTION_BITS - 1));
  assign ry = my_r + (MW'(1) <<< (FRACTION_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r   <= MW'(vx * $signed({1'b0, q}));
      my_r   <= MW'(vy * $signed({1'b0, q}));
      cls1_r <= cls;
      sx1_r  <= sx;
      sy1_r  <= sy;
      ex1_r  <= ex;
      ey1_r  <= ey;
      ix_r   <= sx1_r + COORD_BITS'(rx >>> FRACTION_BITS);
      iy_r   <= sy1_r + COORD_BITS'(ry >>> FRACTION_BITS);
      cls2_r <= cls1_r;
      sx2_r  <= sx1_r;
      sy2_r  <= sy1_r;
      ex2_r  <= ex1_r;
      ey2_r  <= ey1_r;
    end
  end

  assign v_o   = v2_r;
  assign cls_o = cls2_r;
  assign ix_o  = ix_r;
  assign iy_o  = iy_r;
  assign sx_o  = sx2_r;
  assign sy_o  = sy2_r;
  assign ex_o  = ex2_r;
  assign ey_o  = ey2_r;
endmodule

FILE: src/line_side_segment_splitter.sv
// Segment splitter against one configured line. Fully pipelined with stall:
// cross products (3 stages), classification and a restoring divider with one
// quotient bit per stage (FRACTION_BITS+1 stages), cut point (2 stages), then
// an output stage that emits one or two pieces. A segment may enter each
// cycle unless in_stall is high (output stall, or a split whose first piece
// is being emitted); a split holds the pipeline until its second piece goes out.
module line_side_segment_splitter #(
  parameter int COORD_BITS    = lsss_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = lsss_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_seg_start_x,
  input  logic signed [COORD_BITS-1:0]  in_seg_start_y,
  input  logic signed [COORD_BITS-1:0]  in_seg_end_x,
  input  logic signed [COORD_BITS-1:0]  in_seg_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_side,
  output logic signed [COORD_BITS-1:0]  out_out_start_x,
  output logic signed [COORD_BITS-1:0]  out_out_start_y,
  output logic signed [COORD_BITS-1:0]  out_out_end_x,
  output logic signed [COORD_BITS-1:0]  out_out_end_y,
  output logic                          out_was_cut,
  output logic                          out_last_piece,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lsss_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  localparam int XW = 2 * COORD_BITS + 3;

  logic signed [COORD_BITS-1:0] px_r, py_r, dx_r, dy_r;
  logic [lsss_pkg::TOL_BITS-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r  <= '0;
      py_r  <= '0;
      dx_r  <= COORD_BITS'(256);
      dy_r  <= '0;
      tol_r <= lsss_pkg::TOL_BITS'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        lsss_pkg::REG_START_X:  px_r  <= COORD_BITS'(cfg_data);
        lsss_pkg::REG_START_Y:  py_r  <= COORD_BITS'(cfg_data);
        lsss_pkg::REG_DIR_X:    dx_r  <= COORD_BITS'(cfg_data);
        lsss_pkg::REG_DIR_Y:    dy_r  <= COORD_BITS'(cfg_data);
        lsss_pkg::REG_ZERO_TOL: tol_r <= lsss_pkg::TOL_BITS'(cfg_data);
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  logic adv;
  logic c_v, d_v, k_v;
  logic signed [XW-1:0] num, den;
  logic signed [COORD_BITS-1:0] c_sx, c_sy, c_ex, c_ey;
  logic signed [COORD_BITS-1:0] d_sx, d_sy, d_ex, d_ey;
  logic signed [COORD_BITS-1:0] k_sx, k_sy, k_ex, k_ey, k_ix, k_iy;
  logic [FRACTION_BITS-1:0] d_q;
  lsss_pkg::cls_t d_cls, k_cls;

  lsss_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk, .rst_n, .adv, .in_v(in_valid),
    .sx(in_seg_start_x), .sy(in_seg_start_y), .ex(in_seg_end_x), .ey(in_seg_end_y),
    .px(px_r), .py(py_r), .dx(dx_r), .dy(dy_r),
    .v_o(c_v), .num_o(num), .den_o(den),
    .sx_o(c_sx), .sy_o(c_sy), .ex_o(c_ex), .ey_o(c_ey)
  );

  lsss_divide #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk, .rst_n, .adv, .in_v(c_v), .num, .den, .tol(tol_r),
    .sx(c_sx), .sy(c_sy), .ex(c_ex), .ey(c_ey),
    .v_o(d_v), .cls_o(d_cls), .q_o(d_q),
    .sx_o(d_sx), .sy_o(d_sy), .ex_o(d_ex), .ey_o(d_ey)
  );

  lsss_cut #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_cut (
    .clk, .rst_n, .adv, .in_v(d_v), .cls(d_cls), .q(d_q),
    .sx(d_sx), .sy(d_sy), .ex(d_ex), .ey(d_ey),
    .v_o(k_v), .cls_o(k_cls), .ix_o(k_ix), .iy_o(k_iy),
    .sx_o(k_sx), .sy_o(k_sy), .ex_o(k_ex), .ey_o(k_ey)
  );

  // output stage: holds one piece; phase_r marks second piece of a split pending
  logic ov_r, phase_r;
  logic side_r, cut_r, last_r;
  logic signed [COORD_BITS-1:0] osx_r, osy_r, oex_r, oey_r;
  logic split, out_free, take_k;

  assign split    = (k_cls == lsss_pkg::CLS_SPLIT_POS) || (k_cls == lsss_pkg::CLS_SPLIT_NEG);
  assign out_free = !ov_r || !out_stall;
  assign take_k   = k_v && out_free && (!split || phase_r);
  assign adv      = !k_v || take_k;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      phase_r <= 1'b0;
    end else if (out_free) begin
      ov_r <= k_v;
      if (k_v && split) phase_r <= !phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && k_v) begin
      case (k_cls)
        lsss_pkg::CLS_SPLIT_POS: begin
          side_r <= phase_r;
          cut_r  <= 1'b1;
          last_r <= phase_r;
          osx_r  <= phase_r ? k_sx : k_ix;
          osy_r  <= phase_r ? k_sy : k_iy;
          oex_r  <= phase_r ? k_ix : k_ex;
          oey_r  <= phase_r ? k_iy : k_ey;
        end
        lsss_pkg::CLS_SPLIT_NEG: begin
          side_r <= phase_r;
          cut_r  <= 1'b1;
          last_r <= phase_r;
          osx_r  <= phase_r ? k_ix : k_sx;
          osy_r  <= phase_r ? k_iy : k_sy;
          oex_r  <= phase_r ? k_ex : k_ix;
          oey_r  <= phase_r ? k_ey : k_iy;
        end
        default: begin
          side_r <= (k_cls == lsss_pkg::CLS_WHOLE_BACK);
          cut_r  <= 1'b0;
          last_r <= 1'b1;
          osx_r  <= k_sx;
          osy_r  <= k_sy;
          oex_r  <= k_ex;
          oey_r  <= k_ey;
        end
      endcase
    end
  end

  assign out_valid       = ov_r;
  assign out_side        = side_r;
  assign out_out_start_x = osx_r;
  assign out_out_start_y = osy_r;
  assign out_out_end_x   = oex_r;
  assign out_out_end_y   = oey_r;
  assign out_was_cut     = cut_r;
  assign out_last_piece  = last_r;
endmodule

FILE: src/lsss_checker.sv
module lsss_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_side,
  input logic out_was_cut,
  input logic out_last_piece
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_side))
    else $error("stalled result changed");

  a_uncut_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_cut |-> out_last_piece)
    else $error("whole segment not marked last");

  a_cut_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_cut |-> out_side == out_last_piece)
    else $error("split piece side and last disagree");

  a_cut_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_was_cut && !out_last_piece |=>
      out_valid && out_was_cut && out_last_piece)
    else $error("front piece not followed by back piece");
endmodule

bind line_side_segment_splitter lsss_checker u_lsss_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_side, .out_was_cut, .out_last_piece
);

FILE: dv/line_side_segment_splitter_tb.sv
module line_side_segment_splitter_tb;

  localparam int CB = 24;
  localparam int FB = 16;
  localparam int SETTLE = FB + 40;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t sx, sy, ex, ey;
  } seg_req_t;

  typedef struct packed {
    logic   side;
    coord_t sx, sy, ex, ey;
    logic   cut;
    logic   last;
  } piece_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t in_seg_start_x = '0, in_seg_start_y = '0, in_seg_end_x = '0, in_seg_end_y = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   out_side, out_was_cut, out_last_piece;
  coord_t out_out_start_x, out_out_start_y, out_out_end_x, out_out_end_y;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic [lsss_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  line_side_segment_splitter dut (.*);

  logic signed [63:0] spl_px, spl_py, spl_dx, spl_dy;
  logic [23:0] spl_tol;

  seg_req_t seg_queue[$];
  piece_t   piece_queue[$];
  int n_mismatch = 0;
  int n_pieces = 0;
  int n_cuts = 0;
  int n_segs = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic is_zero(logic signed [127:0] c);
    logic [127:0] m;
    m = c < 0 ? -c : c;
    return (c == 0) || (m < {104'd0, spl_tol});
  endfunction

  function automatic logic signed [63:0] scale_round(logic signed [63:0] v, logic [63:0] q);
    logic signed [63:0] p;
    p = v * $signed(q) + (64'sd1 <<< (FB - 1));
    return p >>> FB;
  endfunction

  function automatic piece_t mk(logic s, logic signed [63:0] ax, logic signed [63:0] ay,
                                logic signed [63:0] bx, logic signed [63:0] by,
                                logic c, logic l);
    piece_t p;
    p.side = s; p.sx = ax[CB-1:0]; p.sy = ay[CB-1:0];
    p.ex = bx[CB-1:0]; p.ey = by[CB-1:0]; p.cut = c; p.last = l;
    return p;
  endfunction

  task automatic queue_piece(piece_t p);
    piece_queue = {piece_queue, p};
  endtask

  task automatic predict_split(seg_req_t r);
    logic signed [63:0] sx, sy, ex, ey, vx, vy, ix, iy;
    logic signed [127:0] num, den;
    logic [127:0] rem, dv;
    logic [63:0] q;
    logic nz, dz, nneg, dneg;
    sx = r.sx; sy = r.sy; ex = r.ex; ey = r.ey;
    vx = ex - sx; vy = ey - sy;
    num = 128'(sx - spl_px) * 128'(spl_dy) - 128'(sy - spl_py) * 128'(spl_dx);
    den = 128'(spl_dx) * 128'(vy) - 128'(spl_dy) * 128'(vx);
    nz = is_zero(num); dz = is_zero(den);
    nneg = num < 0; dneg = den < 0;
    if (dz && nz) begin
      queue_piece(mk(1'b0, sx, sy, ex, ey, 1'b0, 1'b1));
      return;
    end
    if (dz) begin
      queue_piece(mk(!nneg, sx, sy, ex, ey, 1'b0, 1'b1));
      return;
    end
    if (num != 0 && nneg == dneg) begin
      rem = nneg ? -num : num;
      dv = dneg ? -den : den;
      if (rem < dv) begin
        q = 0;
        for (int i = 0; i < FB; i++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= dv) begin
            rem = rem - dv;
            q[0] = 1'b1;
          end
        end
        ix = sx + scale_round(vx, q);
        iy = sy + scale_round(vy, q);
        if (!nneg) begin
          queue_piece(mk(1'b0, ix, iy, ex, ey, 1'b1, 1'b0));
          queue_piece(mk(1'b1, sx, sy, ix, iy, 1'b1, 1'b1));
        end else begin
          queue_piece(mk(1'b0, sx, sy, ix, iy, 1'b1, 1'b0));
          queue_piece(mk(1'b1, ix, iy, ex, ey, 1'b1, 1'b1));
        end
        n_cuts++;
        return;
      end
    end
    queue_piece(mk(!(nneg || (nz && !dneg)), sx, sy, ex, ey, 1'b0, 1'b1));
  endtask

  logic in_taken = 1'b0;
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        n_segs++;
      end
      if (in_valid && !in_taken) begin
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (seg_queue.size() > 0) begin
        seg_req_t r;
        r = seg_queue.pop_front();
        predict_split(r);
        in_valid <= 1'b1;
        in_seg_start_x <= r.sx; in_seg_start_y <= r.sy;
        in_seg_end_x <= r.ex; in_seg_end_y <= r.ey;
        in_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  int out_wait = 0;
  always @(negedge clk) begin
    if (out_wait > 0) begin
      out_stall <= 1'b1;
      out_wait <= out_wait - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) out_wait <= $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      piece_t got, want;
      got.side = out_side; got.sx = out_out_start_x; got.sy = out_out_start_y;
      got.ex = out_out_end_x; got.ey = out_out_end_y;
      got.cut = out_was_cut; got.last = out_last_piece;
      n_pieces++;
      if (piece_queue.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected piece %p", got);
      end else begin
        want = piece_queue.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic cfg_write(lsss_pkg::cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lsss_pkg::REG_START_X: spl_px = $signed(val[CB-1:0]);
      lsss_pkg::REG_START_Y: spl_py = $signed(val[CB-1:0]);
      lsss_pkg::REG_DIR_X:   spl_dx = $signed(val[CB-1:0]);
      lsss_pkg::REG_DIR_Y:   spl_dy = $signed(val[CB-1:0]);
      default:               spl_tol = val[23:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (seg_queue.size() > 0 || in_valid || piece_queue.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 4095)) - 2048);
      default: return coord_t'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
    endcase
  endfunction

  task automatic add_seg(coord_t a, coord_t b, coord_t c, coord_t d);
    seg_req_t r;
    r.sx = a; r.sy = b; r.ex = c; r.ey = d;
    seg_queue = {seg_queue, r};
  endtask

  initial begin
    coord_t mx, mn, a, b;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    spl_px = 0; spl_py = 0; spl_dx = 256; spl_dy = 0; spl_tol = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_seg(0, 0, 512, 0);
    add_seg(0, 256, 512, 256);
    add_seg(0, -256, 512, -256);
    add_seg(100, -256, 100, 256);
    add_seg(100, 256, 100, -256);
    add_seg(5, 5, 5, 5);
    add_seg(0, 0, 5, 0);
    add_seg(0, 0, 0, 256);
    add_seg(0, 256, 0, 0);
    add_seg(0, -1, 300, 1000);
    add_seg(mx, mx, mn, mn);
    add_seg(mn, mx, mx, mn);
    add_seg(mn, mn, mx, mx);
    add_seg(mx, mn, mn, mx);
    add_seg(mx, 0, mn, 0);
    add_seg(0, 1, 1, -1);
    add_seg(7, 3, -9, -3);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_write(lsss_pkg::REG_START_X, 32'(-1000));
          cfg_write(lsss_pkg::REG_START_Y, 32'd500);
          cfg_write(lsss_pkg::REG_DIR_X, 32'd300);
          cfg_write(lsss_pkg::REG_DIR_Y, 32'(-700));
          cfg_write(lsss_pkg::REG_ZERO_TOL, 32'd0);
        end
        1: begin
          cfg_write(lsss_pkg::REG_START_X, 32'(mx));
          cfg_write(lsss_pkg::REG_START_Y, 32'(mn));
          cfg_write(lsss_pkg::REG_DIR_X, 32'(mn));
          cfg_write(lsss_pkg::REG_DIR_Y, 32'(mx));
          cfg_write(lsss_pkg::REG_ZERO_TOL, 32'hFFFFFF);
        end
        2: begin
          cfg_write(lsss_pkg::REG_START_X, 32'd0);
          cfg_write(lsss_pkg::REG_START_Y, 32'd0);
          cfg_write(lsss_pkg::REG_DIR_X, 32'd0);
          cfg_write(lsss_pkg::REG_DIR_Y, 32'd0);
          cfg_write(lsss_pkg::REG_ZERO_TOL, 32'd1);
        end
        default: begin
          cfg_write(lsss_pkg::REG_START_X, 32'(rnd_coord(ph % 3)));
          cfg_write(lsss_pkg::REG_START_Y, 32'(rnd_coord(ph % 3)));
          cfg_write(lsss_pkg::REG_DIR_X, 32'(rnd_coord(ph % 3)));
          cfg_write(lsss_pkg::REG_DIR_Y, 32'(rnd_coord(ph % 3)));
          cfg_write(lsss_pkg::REG_ZERO_TOL,
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 1 << 20)
                                              : $urandom_range(0, 64));
        end
      endcase
      for (int i = 0; i < 85; i++) begin
        int m;
        m = $urandom_range(0, 2);
        case ($urandom_range(0, 4))
          0: begin
            a = rnd_coord(m);
            b = rnd_coord(m);
            add_seg(a, b, a, b);
          end
          1: begin
            a = rnd_coord(m);
            b = rnd_coord(m);
            add_seg(a, b, coord_t'(a + spl_dx[CB-1:0]), coord_t'(b + spl_dy[CB-1:0]));
          end
          default: add_seg(rnd_coord(m), rnd_coord(m), rnd_coord(m), rnd_coord(m));
        endcase
      end
      drain();
    end

    $display("segments sent: %0d, pieces checked: %0d, split segments: %0d",
             n_segs, n_pieces, n_cuts);
    $display("covered seven splitter settings including extremes, zero line and tolerance");
    if (n_mismatch == 0 && piece_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
